### src/assert_macros.svh
// Assertion macros used by the decoder top level.
// Depends on nothing; the including module must have clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("decoder assertion failed");

`endif

### src/dvsd_pkg.sv
// Shared types and constants for the delta varint stream decoder.
// Depends on nothing; imported by every decoder module.
package dvsd_pkg;

   localparam logic [6:0] DATA_MASK  = 7'h7F;
   localparam logic [2:0] MAX_BYTES0 = 3'd5;

   localparam logic FORMAT_CONT   = 1'b0;
   localparam logic FORMAT_LENGTH = 1'b1;

   localparam logic CSR_CODE_FORMAT  = 1'b0;
   localparam logic CSR_DELTA_ENABLE = 1'b1;

   typedef struct packed {
      logic code_format;
      logic delta_enable;
   } cfg_type;

   typedef struct packed {
      logic [31:0] gap;
      logic [2:0]  code_bytes;
      logic        clear_sum;
   } code_item_type;

endpackage

### src/dvsd_front.sv
// Front end: accepts stream bytes and assembles codes in either format.
// Depends on dvsd_pkg; pushes finished codes into dvsd_queue.
module dvsd_front
   import dvsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [7:0]    req_code_byte,
   input  logic          req_list_start,
   input  logic          queue_full,
   input  cfg_type       cfg,
   input  logic          format_write,
   output logic          push,
   output code_item_type push_item,
   output logic          code_open
);

   logic [31:0] partial_ff, partial_in;
   logic [2:0]  taken_ff, taken_in;
   logic [1:0]  needed_ff, needed_in;
   logic        clr_pending_ff, clr_pending_in;

   logic        accept;
   logic        done;
   logic [2:0]  count;
   logic [31:0] base_value;
   logic [31:0] next_value;
   logic [1:0]  next_needed;
   logic [1:0]  lane;
   logic        clear_eff;

   assign accept    = req_valid && !queue_full;
   assign clear_eff = clr_pending_ff || req_list_start;
   assign count     = (req_list_start ? 3'd0 : taken_ff) + 3'd1;
   assign base_value = req_list_start ? 32'd0 : partial_ff;
   assign lane      = 2'(count - 3'd1);

   always_comb begin
      next_needed = req_list_start ? 2'd0 : needed_ff;
      if (cfg.code_format == FORMAT_CONT) begin
         next_value = {base_value[24:0], req_code_byte[6:0] & DATA_MASK};
         done = !req_code_byte[7] || (count >= MAX_BYTES0);
      end else begin
         if (count == 3'd1) begin
            next_needed = req_code_byte[1:0];
            next_value = {24'd0, req_code_byte};
         end else begin
            next_value = base_value | ({24'd0, req_code_byte} << {lane, 3'b000});
         end
         done = count >= ({1'b0, next_needed} + 3'd1);
      end
   end

   always_comb begin
      partial_in     = partial_ff;
      taken_in       = taken_ff;
      needed_in      = needed_ff;
      clr_pending_in = clr_pending_ff;
      if (format_write) begin
         partial_in = 32'd0;
         taken_in   = 3'd0;
         needed_in  = 2'd0;
      end else if (accept) begin
         if (done) begin
            partial_in     = 32'd0;
            taken_in       = 3'd0;
            needed_in      = 2'd0;
            clr_pending_in = 1'b0;
         end else begin
            partial_in     = next_value;
            taken_in       = count;
            needed_in      = next_needed;
            clr_pending_in = clear_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff     <= 32'd0;
         taken_ff       <= 3'd0;
         needed_ff      <= 2'd0;
         clr_pending_ff <= 1'b0;
      end else begin
         partial_ff     <= partial_in;
         taken_ff       <= taken_in;
         needed_ff      <= needed_in;
         clr_pending_ff <= clr_pending_in;
      end
   end

   assign push = accept && done && !format_write;
   assign push_item.gap = (cfg.code_format == FORMAT_LENGTH) ?
                          {2'b00, next_value[31:2]} : next_value;
   assign push_item.code_bytes = count;
   assign push_item.clear_sum  = clear_eff;
   assign code_open = taken_ff != 3'd0;

endmodule

### src/dvsd_queue.sv
// Two-entry queue of finished codes between the front and back ends.
// Depends on dvsd_pkg for the code item type.
module dvsd_queue
   import dvsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  code_item_type push_item,
   input  logic          pop,
   output code_item_type pop_item,
   output logic          full,
   output logic          empty
);

   code_item_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;

endmodule

### src/dvsd_back.sv
// Back end: keeps the running sum and holds the result register.
// Depends on dvsd_pkg; takes codes from dvsd_queue.
module dvsd_back
   import dvsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          queue_empty,
   input  code_item_type queue_item,
   input  cfg_type       cfg,
   input  logic          rsp_stall,
   output logic          pop,
   output logic          rsp_valid,
   output logic [31:0]   rsp_value,
   output logic [31:0]   rsp_gap,
   output logic [2:0]    rsp_code_bytes
);

   logic [31:0] sum_ff, sum_in;
   logic        valid_ff, valid_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] gap_ff;
   logic [2:0]  bytes_ff;

   assign pop      = !queue_empty && (!valid_ff || !rsp_stall);
   assign sum_in   = (queue_item.clear_sum ? 32'd0 : sum_ff) + queue_item.gap;
   assign value_in = cfg.delta_enable ? sum_in : queue_item.gap;
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 32'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff <= value_in;
         gap_ff   <= queue_item.gap;
         bytes_ff <= queue_item.code_bytes;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_gap        = gap_ff;
   assign rsp_code_bytes = bytes_ff;

endmodule

### src/delta_varint_stream_decoder_core.sv
// Top level of the delta varint stream decoder: config registers and wiring.
// Depends on dvsd_pkg, assert_macros.svh, dvsd_front, dvsd_queue and dvsd_back.

// The decoder takes one stream byte per cycle while req_stall is low and emits
// a result when a code ends, through a queue entry and the result register.
// Bytes are taken at one per cycle as long as results are taken, since the
// front end assembles a code a byte at a time and the back end adds one gap
// to the running sum per cycle. A two-entry queue sits between them, so req_stall
// rises only once a stall on the result side has filled it. Configuration is
// written through a one-bit index, by the user only while the block is idle; the
// block does not enforce it. Changing the code format drops any code in progress.
`include "assert_macros.svh"

module delta_varint_stream_decoder_core
   import dvsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_list_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic [31:0] rsp_gap,
   output logic [2:0]  rsp_code_bytes,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic        csr_write_data
);

   cfg_type       cfg_ff, cfg_in;
   logic          format_write;
   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   code_item_type push_item;
   code_item_type pop_item;
   logic          code_open;

   assign format_write = csr_write_enable && (csr_index == CSR_CODE_FORMAT);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CODE_FORMAT: begin
               cfg_in.code_format = csr_write_data;
            end
            CSR_DELTA_ENABLE: begin
               cfg_in.delta_enable = csr_write_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_format  <= FORMAT_LENGTH;
         cfg_ff.delta_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   dvsd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_code_byte  (req_code_byte),
      .req_list_start (req_list_start),
      .queue_full     (q_full),
      .cfg            (cfg_ff),
      .format_write   (format_write),
      .push           (q_push),
      .push_item      (push_item),
      .code_open      (code_open)
   );

   dvsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   dvsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (q_empty),
      .queue_item     (pop_item),
      .cfg            (cfg_ff),
      .rsp_stall      (rsp_stall),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value),
      .rsp_gap        (rsp_gap),
      .rsp_code_bytes (rsp_code_bytes)
   );

   `ASSERT_NOW(a_queue_no_overflow, q_push, !q_full)
   `ASSERT_NOW(a_queue_no_underflow, q_pop, !q_empty)
   `ASSERT_NEXT(a_format_write_clears, format_write, !code_open)

endmodule
